// ===== rtl/srtc_pkg.sv =====
// ----------------------------------------------------------------------------
// srtc_pkg
// Shared types and codes for the selective retransmit controller: event kinds,
// task reasons, register indexes and the structs passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package srtc_pkg;

   localparam int PSN_BITS      = 24;
   localparam int INTERVAL_BITS = 16;
   localparam int DCOUNT_BITS   = 32;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 16;

   // event kinds carried on the request channel
   typedef enum logic [1:0] {
      EV_DATA = 2'd0,
      EV_ACK  = 2'd1,
      EV_NAK  = 2'd2,
      EV_TICK = 2'd3
   } event_kind_type;

   // task reason codes
   localparam logic REASON_SELECTIVE = 1'b0;
   localparam logic REASON_GO_BACK_N = 1'b1;

   // gateway roles
   localparam logic ROLE_DESTINATION = 1'b0;
   localparam logic ROLE_SOURCE      = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_GATEWAY_ROLE   = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RETRY_INTERVAL = 1'd1;

   localparam logic [INTERVAL_BITS-1:0] RETRY_INTERVAL_RESET = 16'd10;

   // one captured event
   typedef struct packed {
      event_kind_type      kind;
      logic [PSN_BITS-1:0] psn;
      logic                cached;
   } event_type;

   // one result item
   typedef struct packed {
      logic                   task_valid;
      logic                   task_reason;
      logic [PSN_BITS-1:0]    task_psn;
      logic [DCOUNT_BITS-1:0] data_count;
   } result_type;

   // handshake between the stages
   typedef struct packed {
      logic advance;
      logic space;
   } stage_ctrl_type;

endpackage : srtc_pkg

`default_nettype wire

// ===== rtl/srtc_in_stage.sv =====
// ----------------------------------------------------------------------------
// srtc_in_stage
// Input register: captures one event per transfer and holds it until the
// core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module srtc_in_stage
   import srtc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_kind,
   input  wire logic [PSN_BITS-1:0] req_psn,
   input  wire logic                req_cached,
   input  wire stage_ctrl_type      ctrl,
   output logic                     evt_valid,
   output event_type                evt
);

   logic      valid_ff;
   logic      valid_in;
   event_type evt_ff;
   logic      take;

   // accept when empty or when the held event moves on this cycle
   assign req_ready = !valid_ff || ctrl.advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (ctrl.advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (take) begin
         evt_ff.kind   <= event_kind_type'(req_kind);
         evt_ff.psn    <= req_psn;
         evt_ff.cached <= req_cached;
      end
   end

   assign evt_valid = valid_ff;
   assign evt       = evt_ff;

endmodule : srtc_in_stage

`default_nettype wire

// ===== rtl/srtc_core.sv =====
// ----------------------------------------------------------------------------
// srtc_core
// Connection state, configuration registers and the per-event update that
// decides whether a retransmit task is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module srtc_core
   import srtc_pkg::*;
#(
   parameter int TIMER_BITS = 16,
   parameter int COUNT_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  wire logic                     fire,
   input  wire event_type                evt,
   output result_type                    result
);

   localparam logic [63:0] TIMER_MAX64 = (64'd1 << TIMER_BITS) - 64'd1;
   localparam logic [31:0] TIMER_MAX   = TIMER_MAX64[31:0];

   logic                     gateway_role_ff;
   logic [INTERVAL_BITS-1:0] retry_interval_ff;

   logic                  request_pending_ff, request_pending_in;
   logic [PSN_BITS-1:0]   nak_seq_ff, nak_seq_in;
   logic                  nak_seq_valid_ff, nak_seq_valid_in;
   logic [TIMER_BITS-1:0] timer_left_ff, timer_left_in;
   logic                  timer_armed_ff, timer_armed_in;
   logic [COUNT_BITS-1:0] packets_seen_ff, packets_seen_in;

   logic [INTERVAL_BITS-1:0] load_raw;
   logic [TIMER_BITS-1:0]    timer_load;
   logic [TIMER_BITS-1:0]    timer_dec;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gateway_role_ff   <= ROLE_DESTINATION;
         retry_interval_ff <= RETRY_INTERVAL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_GATEWAY_ROLE:   gateway_role_ff   <= csr_wdata[0];
            CSR_RETRY_INTERVAL: retry_interval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // timer reload value: zero acts as one, saturate to the timer range
   always_comb begin
      load_raw = (retry_interval_ff == '0) ? INTERVAL_BITS'(1) : retry_interval_ff;
      if (32'(load_raw) > TIMER_MAX) begin
         timer_load = '1;
      end else begin
         timer_load = TIMER_BITS'(load_raw);
      end
   end

   assign timer_dec = timer_left_ff - TIMER_BITS'(1);

   // event update
   always_comb begin
      request_pending_in = request_pending_ff;
      nak_seq_in         = nak_seq_ff;
      nak_seq_valid_in   = nak_seq_valid_ff;
      timer_left_in      = timer_left_ff;
      timer_armed_in     = timer_armed_ff;
      packets_seen_in    = packets_seen_ff;
      result.task_valid  = 1'b0;
      result.task_reason = REASON_SELECTIVE;
      result.task_psn    = '0;

      unique case (evt.kind)
         EV_DATA: begin
            if (request_pending_ff) begin
               if (nak_seq_valid_ff && (evt.psn == nak_seq_ff)) begin
                  request_pending_in = 1'b0;
                  nak_seq_valid_in   = 1'b0;
                  nak_seq_in         = '0;
                  timer_armed_in     = 1'b0;
                  timer_left_in      = '0;
               end else begin
                  timer_left_in  = timer_load;
                  timer_armed_in = 1'b1;
               end
            end
            packets_seen_in = packets_seen_ff + COUNT_BITS'(1);
         end
         EV_ACK: begin
            request_pending_in = 1'b0;
            nak_seq_valid_in   = 1'b0;
            nak_seq_in         = '0;
            timer_armed_in     = 1'b0;
            timer_left_in      = '0;
         end
         EV_NAK: begin
            if (gateway_role_ff == ROLE_DESTINATION) begin
               if (evt.cached) begin
                  result.task_valid  = 1'b1;
                  result.task_reason = REASON_GO_BACK_N;
                  result.task_psn    = evt.psn;
               end else if (!nak_seq_valid_ff || (evt.psn > nak_seq_ff)) begin
                  nak_seq_in         = evt.psn;
                  nak_seq_valid_in   = 1'b1;
                  request_pending_in = 1'b1;
                  timer_left_in      = timer_load;
                  timer_armed_in     = 1'b1;
               end
            end
         end
         EV_TICK: begin
            if (timer_armed_ff) begin
               timer_left_in = timer_dec;
               if (timer_dec == '0) begin
                  timer_armed_in = 1'b0;
                  if (request_pending_ff) begin
                     result.task_valid  = 1'b1;
                     result.task_reason = REASON_SELECTIVE;
                     result.task_psn    = nak_seq_ff;
                     request_pending_in = 1'b0;
                  end
               end
            end
         end
         default: ;
      endcase

      result.data_count = DCOUNT_BITS'(packets_seen_in);
   end

   // state registers, updated once per consumed event
   always_ff @(posedge clock) begin
      if (reset) begin
         request_pending_ff <= 1'b0;
         nak_seq_ff         <= '0;
         nak_seq_valid_ff   <= 1'b0;
         timer_left_ff      <= '0;
         timer_armed_ff     <= 1'b0;
         packets_seen_ff    <= '0;
      end else if (fire) begin
         request_pending_ff <= request_pending_in;
         nak_seq_ff         <= nak_seq_in;
         nak_seq_valid_ff   <= nak_seq_valid_in;
         timer_left_ff      <= timer_left_in;
         timer_armed_ff     <= timer_armed_in;
         packets_seen_ff    <= packets_seen_in;
      end
   end

   // a pending request always runs its timer
   a_pending_armed: assert property (@(posedge clock) disable iff (reset)
      request_pending_ff == timer_armed_ff)
      else $error("request pending and timer armed disagree");

   // a pending request has a recorded psn
   a_pending_seq: assert property (@(posedge clock) disable iff (reset)
      request_pending_ff |-> nak_seq_valid_ff)
      else $error("request pending without recorded psn");

   // an armed timer never sits at zero
   a_armed_nonzero: assert property (@(posedge clock) disable iff (reset)
      timer_armed_ff |-> (timer_left_ff != '0))
      else $error("armed timer at zero");

   // the data counter moves only on a consumed data event
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (packets_seen_ff != $past(packets_seen_ff)) |->
         ($past(fire) && ($past(evt.kind) == EV_DATA)))
      else $error("data counter moved without a data event");

endmodule : srtc_core

`default_nettype wire

// ===== rtl/srtc_out_stage.sv =====
// ----------------------------------------------------------------------------
// srtc_out_stage
// Result register: holds one result until the response transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module srtc_out_stage
   import srtc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   evt_valid,
   input  wire result_type             result,
   output stage_ctrl_type              ctrl,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_task_valid,
   output logic                        rsp_task_reason,
   output logic [PSN_BITS-1:0]         rsp_task_psn,
   output logic [DCOUNT_BITS-1:0]      rsp_data_count
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // room when empty or when the held result leaves this cycle
   assign ctrl.space   = !valid_ff || rsp_ready;
   assign ctrl.advance = evt_valid && ctrl.space;

   always_comb begin
      valid_in = valid_ff;
      if (ctrl.advance) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_task_valid  = result_ff.task_valid;
   assign rsp_task_reason = result_ff.task_reason;
   assign rsp_task_psn    = result_ff.task_psn;
   assign rsp_data_count  = result_ff.data_count;

endmodule : srtc_out_stage

`default_nettype wire

// ===== rtl/selective_retransmit_controller.sv =====
// ----------------------------------------------------------------------------
// selective_retransmit_controller
// Per-connection retransmit control: as destination, go-back-N on cached NAKs,
// a timed selective request on uncached newer NAKs; cancel/rearm on data, clear on ACK.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   req     | in        | req_valid/req_ready  | kind, psn, cached
//   rsp     | out       | rsp_valid/rsp_ready  | task_valid/reason/psn, count
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One event per cycle while rsp_ready keeps the result register free; a request
// passes the input register, then the result register, before rsp_valid rises.
// The event update is a single pass of compares, one counter add and one timer
// decrement.
// Reset is synchronous; it clears state, sets role to destination and the
// retry interval to 10. A stalled rsp side backs up through both registers
// before req_ready drops. csr writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_retransmit_controller
   import srtc_pkg::*;
#(
   parameter int TIMER_BITS = 16,
   parameter int COUNT_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_kind,
   input  wire logic [PSN_BITS-1:0]      req_psn,
   input  wire logic                     req_cached,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_task_valid,
   output logic                          rsp_task_reason,
   output logic [PSN_BITS-1:0]           rsp_task_psn,
   output logic [DCOUNT_BITS-1:0]        rsp_data_count,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   stage_ctrl_type ctrl;
   logic           evt_valid;
   event_type      evt;
   result_type     result;

   assign csr_ready = 1'b1;

   // input register
   srtc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_kind   (req_kind),
      .req_psn    (req_psn),
      .req_cached (req_cached),
      .ctrl       (ctrl),
      .evt_valid  (evt_valid),
      .evt        (evt)
   );

   // state and event update
   srtc_core #(
      .TIMER_BITS (TIMER_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (ctrl.advance),
      .evt       (evt),
      .result    (result)
   );

   // result register
   srtc_out_stage u_out_stage (
      .clock           (clock),
      .reset           (reset),
      .evt_valid       (evt_valid),
      .result          (result),
      .ctrl            (ctrl),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_task_valid  (rsp_task_valid),
      .rsp_task_reason (rsp_task_reason),
      .rsp_task_psn    (rsp_task_psn),
      .rsp_data_count  (rsp_data_count)
   );

endmodule : selective_retransmit_controller

`default_nettype wire
